/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition that must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* hw/rtl/snf_pkg.sv */
package snf_pkg;

  // link mtu limits and packet overheads
  localparam logic [9:0] MTU_MIN    = 10'd23;
  localparam logic [9:0] MTU_MAX    = 10'd517;
  localparam logic [9:0] FRAG_OVH   = 10'd7;
  localparam logic [9:0] SINGLE_OVH = 10'd3;

  // fragment header marker byte
  localparam logic [7:0] HDR_MARK = 8'h23;

  // configuration register indexes
  localparam logic [1:0] REG_MTU    = 2'd0;
  localparam logic [1:0] REG_NOTIFY = 2'd1;

  // configuration as seen by the front end
  typedef struct packed {
    logic [9:0] mtu;
    logic       notify;
  } snf_cfg_t;

  // one classified message byte, queued between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       pend;
    logic       last;
    logic [7:0] total;
    logic [7:0] idx;
  } snf_entry_t;

endpackage

/* hw/rtl/snf_div.sv */
module snf_div #(
  parameter int unsigned NUM_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [8:0]       den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [8:0]       rem_r, rem_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [8:0]       den_r, den_nxt;
  logic [9:0]       trial;
  logic [9:0]       diff;
  logic             ge;

  // one restoring step per cycle
  assign trial = {rem_r, q_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      q_nxt    = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[8:0] : trial[8:0];
      q_nxt   = {q_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

/* hw/rtl/snf_front.sv */
`include "assert_macros.svh"

module snf_front #(
  parameter int unsigned MAX_MESSAGE_BYTES = 4080
) (
  input  logic                clk,
  input  logic                rst_n,
  input  snf_pkg::snf_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_first_of_message,
  input  logic [11:0]         in_message_length,
  input  logic                q_full,
  output logic                q_push,
  output snf_pkg::snf_entry_t q_entry
);
  import snf_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int unsigned NUM_W = $clog2(MAX_MESSAGE_BYTES + 510);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             active_r, active_nxt;
  logic             frag_r, frag_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] seen_r, seen_nxt;
  logic [8:0]       fill_r, fill_nxt;
  logic [8:0]       cs_r, cs_nxt;
  logic [7:0]       total_r, total_nxt;
  logic [7:0]       idx_r, idx_nxt;
  logic [7:0]       held_r, held_nxt;

  logic             in_xfer;
  logic [9:0]       mtu_c;
  logic [9:0]       mtu_m7;
  logic [8:0]       cs_new;
  logic [LEN_W-1:0] len_new;
  logic             len_ok;
  logic             single;
  logic             start_now;
  logic             proc;
  logic [7:0]       byte_c;
  logic             eff_frag;
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] eff_seen;
  logic [8:0]       eff_fill;
  logic [8:0]       eff_cs;
  logic [LEN_W-1:0] seen1;
  logic [8:0]       fill1;
  logic             last;
  logic             pend;
  logic             hdr;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_num;
  logic [NUM_W-1:0] div_quo;

  assign in_stall = (state_r != ST_IDLE) || q_full;
  assign in_xfer  = in_valid && !in_stall;

  // sample and clamp the mtu at message start
  always_comb begin
    mtu_c = cfg.mtu;
    if (cfg.mtu < MTU_MIN) mtu_c = MTU_MIN;
    if (cfg.mtu > MTU_MAX) mtu_c = MTU_MAX;
  end

  assign mtu_m7    = mtu_c - FRAG_OVH;
  assign cs_new    = mtu_m7[8:0];
  assign len_new   = in_message_length[LEN_W-1:0];
  assign len_ok    = cfg.notify && (in_message_length != 12'd0) &&
                     (in_message_length <= 12'(MAX_MESSAGE_BYTES));
  assign single    = in_message_length <= {2'b00, mtu_c - SINGLE_OVH};
  assign start_now = in_xfer && in_first_of_message && len_ok;
  assign div_start = start_now && !single;
  assign div_num   = NUM_W'(len_new) + NUM_W'(cs_new) - NUM_W'(1);

  // message state as this byte sees it
  assign eff_frag = start_now ? 1'b0    : frag_r;
  assign eff_len  = start_now ? len_new : len_r;
  assign eff_seen = start_now ? '0      : seen_r;
  assign eff_fill = start_now ? '0      : fill_r;
  assign eff_cs   = start_now ? cs_new  : cs_r;

  assign proc = (in_xfer && (in_first_of_message ? (len_ok && single) : active_r)) ||
                (state_r == ST_POST && !q_full);
  assign byte_c = (state_r == ST_POST) ? held_r : in_data_byte;

  // classify the byte
  assign seen1 = eff_seen + LEN_W'(1);
  assign fill1 = eff_fill + 9'd1;
  assign last  = seen1 == eff_len;
  assign hdr   = eff_frag && (eff_fill == 9'd0);
  assign pend  = last || (eff_frag && (fill1 >= eff_cs));

  always_comb begin
    q_push        = proc;
    q_entry.data  = byte_c;
    q_entry.hdr   = hdr;
    q_entry.pend  = pend;
    q_entry.last  = last;
    q_entry.total = total_r;
    q_entry.idx   = idx_r;
  end

  // message bookkeeping
  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    frag_nxt   = frag_r;
    len_nxt    = len_r;
    seen_nxt   = seen_r;
    fill_nxt   = fill_r;
    cs_nxt     = cs_r;
    total_nxt  = total_r;
    idx_nxt    = idx_r;
    held_nxt   = held_r;
    if (in_xfer && in_first_of_message) begin
      active_nxt = len_ok;
      if (len_ok) begin
        frag_nxt  = !single;
        len_nxt   = len_new;
        seen_nxt  = '0;
        fill_nxt  = '0;
        cs_nxt    = cs_new;
        total_nxt = 8'd0;
        idx_nxt   = single ? 8'd0 : 8'd1;
        if (!single) begin
          state_nxt = ST_DIV;
          held_nxt  = in_data_byte;
        end
      end
    end
    if (state_r == ST_DIV && div_done) begin
      total_nxt = div_quo[7:0];
      state_nxt = ST_POST;
    end
    if (proc) begin
      seen_nxt = seen1;
      if (eff_frag) begin
        fill_nxt = pend ? 9'd0 : fill1;
        if (pend) idx_nxt = idx_r + 8'd1;
      end
      if (last) active_nxt = 1'b0;
      if (state_r == ST_POST) state_nxt = ST_IDLE;
    end
  end

  // fragment count
  snf_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (cs_new),
    .done  (div_done),
    .quo   (div_quo)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      active_r <= 1'b0;
      frag_r   <= 1'b0;
      len_r    <= '0;
      seen_r   <= '0;
      fill_r   <= '0;
      cs_r     <= '0;
      total_r  <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      frag_r   <= frag_nxt;
      len_r    <= len_nxt;
      seen_r   <= seen_nxt;
      fill_r   <= fill_nxt;
      cs_r     <= cs_nxt;
      total_r  <= total_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // held first byte of a fragmented message
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  `ASSERT_NEVER(a_done_outside_div, clk, rst_n, div_done && (state_r != ST_DIV), "divider done outside division")
  `ASSERT_NEVER(a_push_when_full, clk, rst_n, q_push && q_full, "push into a full queue")

endmodule

/* hw/rtl/snf_queue.sv */
`include "assert_macros.svh"

module snf_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  snf_pkg::snf_entry_t wr_entry,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output snf_pkg::snf_entry_t head
);
  import snf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  snf_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = count_r == CNT_W'(DEPTH);
  assign q_valid = count_r != '0;
  assign head    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wr_entry;
  end

  `ASSERT_NEVER(a_count_range, clk, rst_n, count_r > CNT_W'(DEPTH), "queue count beyond depth")
  `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !q_valid, "pop from an empty queue")

endmodule

/* hw/rtl/snf_back.sv */
`include "assert_macros.svh"

module snf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  snf_pkg::snf_entry_t head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_packet_end,
  output logic                out_message_end
);
  import snf_pkg::*;

  localparam logic [2:0] PH_MARK0 = 3'd0;
  localparam logic [2:0] PH_MARK1 = 3'd1;
  localparam logic [2:0] PH_TOTAL = 3'd2;
  localparam logic [2:0] PH_INDEX = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;

  logic [2:0] phase_r, phase_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       pe_r, pe_nxt;
  logic       me_r, me_nxt;
  logic       load;
  logic       is_data;
  logic [7:0] byte_sel;

  assign load    = q_valid && (!valid_r || !out_stall);
  assign is_data = !head.hdr || (phase_r == PH_DATA);
  assign q_pop   = load && is_data;

  // pick the byte for the current phase
  always_comb begin
    case (phase_r)
      PH_MARK0: byte_sel = HDR_MARK;
      PH_MARK1: byte_sel = HDR_MARK;
      PH_TOTAL: byte_sel = head.total;
      PH_INDEX: byte_sel = head.idx;
      default:  byte_sel = head.data;
    endcase
    if (is_data) byte_sel = head.data;
  end

  // output register
  always_comb begin
    phase_nxt = phase_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    pe_nxt    = pe_r;
    me_nxt    = me_r;
    if (load) begin
      valid_nxt = 1'b1;
      byte_nxt  = byte_sel;
      pe_nxt    = is_data && head.pend;
      me_nxt    = is_data && head.last;
      phase_nxt = is_data ? PH_MARK0 : phase_r + 3'd1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MARK0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    pe_r   <= pe_nxt;
    me_r   <= me_nxt;
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_packet_end  = pe_r;
  assign out_message_end = me_r;

  `ASSERT_AT(a_header_head_held, clk, rst_n, (phase_r != PH_MARK0) |-> (q_valid && head.hdr), "header phase without a header entry")
  `ASSERT_NEVER(a_phase_range, clk, rst_n, phase_r > PH_DATA, "phase past the data byte")

endmodule

/* hw/rtl/serial_to_notification_fragmenter.sv */
// channel  direction  ports
// in       input      in_valid, in_stall, in_data_byte, in_first_of_message, in_message_length
// out      output     out_valid, out_stall, out_byte, out_packet_end, out_message_end
// cfg      input      cfg_valid, cfg_ready, cfg_index, cfg_data
//
// each byte of an open message yields one output byte, or 5 when it opens a fragment and
// carries the 4 header bytes, from the back end output register at one byte per cycle
// unless out_stall holds it; the first byte of a fragmented message also adds the
// fragment-count divider, one quotient bit a cycle
// synchronous active-low reset clears control state; no clearing pass is needed
// out_stall backs up into the queue and then in_stall; cfg is always ready
module serial_to_notification_fragmenter #(
  parameter int unsigned MAX_MESSAGE_BYTES = 4080,
  parameter int unsigned QUEUE_DEPTH       = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_of_message,
  input  logic [11:0] in_message_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_packet_end,
  output logic        out_message_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import snf_pkg::*;

  logic [9:0] mtu_r, mtu_nxt;
  logic       notify_r, notify_nxt;
  snf_cfg_t   cfg;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  snf_entry_t q_wr;
  snf_entry_t q_head;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    mtu_nxt    = mtu_r;
    notify_nxt = notify_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MTU:    mtu_nxt    = cfg_data;
        REG_NOTIFY: notify_nxt = cfg_data[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtu_r    <= MTU_MIN;
      notify_r <= 1'b0;
    end else begin
      mtu_r    <= mtu_nxt;
      notify_r <= notify_nxt;
    end
  end

  assign cfg.mtu    = mtu_r;
  assign cfg.notify = notify_r;

  // accept and classify
  snf_front #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_first_of_message (in_first_of_message),
    .in_message_length   (in_message_length),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_entry             (q_wr)
  );

  // decoupling queue
  snf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .head     (q_head)
  );

  // header insertion and output
  snf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .head            (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_packet_end  (out_packet_end),
    .out_message_end (out_message_end)
  );

endmodule

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import snf_pkg::*;

  localparam int unsigned MAX_MSG       = 4080;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          RAND_ITEMS    = 450;
  localparam int          CYCLE_LIMIT   = 500000;

  // one packet byte as it leaves the block
  typedef struct packed {
    logic [7:0] b;
    logic       pe;
    logic       me;
  } beat_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_BYTE, EXP_HDR} exp_kind_t;

  // one line of the directed table
  typedef struct packed {
    row_kind_t  kind;
    logic [1:0] reg_idx;
    logic [9:0] reg_val;
    logic [7:0] data;
    logic       first;
    logic [11:0] len;
    exp_kind_t  chk;
    logic       pe;
    logic       me;
    logic [7:0] total;
    logic [7:0] idx;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_first_of_message;
  logic [11:0] in_message_length;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_packet_end;
  logic        out_message_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;

  // fragmenter state as the testbench tracks it
  logic [9:0]  cfg_mtu     = MTU_MIN;
  logic        cfg_notify  = 1'b0;
  logic        msg_open    = 1'b0;
  logic        frag_mode   = 1'b0;
  logic [11:0] msg_len     = '0;
  logic [11:0] byte_count  = '0;
  logic [8:0]  chunk_count = '0;
  logic [7:0]  frag_total  = '0;
  logic [7:0]  frag_idx    = '0;
  logic [9:0]  chunk_len   = '0;

  beat_t step_beats[$];
  beat_t packet_bytes_due[$];
  row_t  opening_rows[$];

  int bad_bytes  = 0;
  int busy_items = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int stall_left = 0;
  int cycles     = 0;

  serial_to_notification_fragmenter #(
    .MAX_MESSAGE_BYTES(MAX_MSG)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_first_of_message (in_first_of_message),
    .in_message_length   (in_message_length),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_packet_end      (out_packet_end),
    .out_message_end     (out_message_end),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // packet bytes caused by one accepted serial byte, left in step_beats
  function automatic void fragment_input_byte(input logic [7:0] d, input logic f,
                                              input logic [11:0] l);
    logic [9:0] mtu;
    logic last;
    logic pend;
    step_beats.delete();
    // a first byte samples the config and opens (or drops) a message
    if (f) begin
      mtu = cfg_mtu;
      msg_open = 1'b0;
      if (cfg_notify && l != 12'd0 && l <= MAX_MSG) begin
        if (mtu < MTU_MIN) mtu = MTU_MIN;
        if (mtu > MTU_MAX) mtu = MTU_MAX;
        msg_open    = 1'b1;
        msg_len     = l;
        byte_count  = '0;
        chunk_count = '0;
        chunk_len   = mtu - FRAG_OVH;
        if (l <= mtu - SINGLE_OVH) begin
          frag_mode  = 1'b0;
          frag_total = '0;
          frag_idx   = '0;
        end else begin
          frag_mode  = 1'b1;
          frag_total = 8'((int'(l) + int'(chunk_len) - 1) / int'(chunk_len));
          frag_idx   = 8'd1;
        end
      end
    end
    if (!msg_open) return;
    byte_count = byte_count + 12'd1;
    last = (byte_count == msg_len);
    if (!frag_mode) begin
      step_beats.push_back(beat_t'{d, last, last});
    end else begin
      // header leads every fragment
      if (chunk_count == 9'd0) begin
        step_beats.push_back(beat_t'{HDR_MARK, 1'b0, 1'b0});
        step_beats.push_back(beat_t'{HDR_MARK, 1'b0, 1'b0});
        step_beats.push_back(beat_t'{frag_total, 1'b0, 1'b0});
        step_beats.push_back(beat_t'{frag_idx, 1'b0, 1'b0});
      end
      chunk_count = chunk_count + 9'd1;
      pend = last || (chunk_count >= chunk_len);
      step_beats.push_back(beat_t'{d, pend, last});
      if (pend) begin
        chunk_count = '0;
        frag_idx = frag_idx + 8'd1;
      end
    end
    if (last) msg_open = 1'b0;
  endfunction

  function automatic row_t item_row(input logic [7:0] d, input logic f, input logic [11:0] l,
                                    input exp_kind_t chk, input logic pe = 1'b0,
                                    input logic me = 1'b0, input logic [7:0] total = 8'd0,
                                    input logic [7:0] idx = 8'd0);
    return row_t'{ROW_ITEM, REG_MTU, 10'd0, d, f, l, chk, pe, me, total, idx};
  endfunction

  function automatic row_t cfg_row(input logic [1:0] idx, input logic [9:0] val);
    return row_t'{ROW_CFG, idx, val, 8'd0, 1'b0, 12'd0, EXP_NONE, 1'b0, 1'b0, 8'd0, 8'd0};
  endfunction

  // one transfer on the serial side, then the prediction for it
  task automatic send_item(input logic [7:0] d, input logic f, input logic [11:0] l);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_data_byte        <= d;
    in_first_of_message <= f;
    in_message_length   <= l;
    do @(posedge clk); while (in_stall);
    fragment_input_byte(d, f, l);
  endtask

  task automatic wait_drained();
    while (packet_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only once the block has gone quiet
  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MTU) cfg_mtu = val;
    else if (idx == REG_NOTIFY) cfg_notify = val[0];
  endtask

  // random item with predicted bytes queued
  task automatic feed(input logic [7:0] d, input logic f, input logic [11:0] l);
    if (busy_items >= RAND_ITEMS - 80) begin
      idle_pct  = 0;
      stall_pct = 0;
    end
    send_item(d, f, l);
    busy_items++;
    foreach (step_beats[i]) packet_bytes_due.push_back(step_beats[i]);
  endtask

  // receiver stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare every output transfer with the oldest predicted byte
  always @(posedge clk) begin : check_out
    beat_t got;
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = beat_t'{out_byte, out_packet_end, out_message_end};
      if (packet_bytes_due.size() == 0) begin
        bad_bytes++;
        if (bad_bytes <= 10)
          $display("unexpected packet byte %h pe %b me %b", got.b, got.pe, got.me);
      end else begin
        want = packet_bytes_due.pop_front();
        if (got.b !== want.b || got.pe !== want.pe || got.me !== want.me) begin
          bad_bytes++;
          if (bad_bytes <= 10)
            $display("packet byte mismatch: expected %h pe %b me %b, got %h pe %b me %b",
                     want.b, want.pe, want.me, got.b, got.pe, got.me);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    row_t row;
    int   r;
    int   s;
    int   len;
    int   nsend;
    int   mtu_pick;
    int   eff;
    int   chunk;
    int   hi;
    int   msgs;
    logic opens;

    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_data_byte        = '0;
    in_first_of_message = 1'b0;
    in_message_length   = '0;
    out_stall           = 1'b0;
    cfg_valid           = 1'b0;
    cfg_index           = REG_MTU;
    cfg_data            = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: reset defaults, drops, length and mtu extremes, mid-message writes
    opening_rows = {
      item_row(8'h00, 1'b1, 12'd1, EXP_NONE),
      item_row(8'hFF, 1'b0, 12'hFFF, EXP_NONE),
      cfg_row(REG_NOTIFY, 10'h001),
      item_row(8'hA5, 1'b1, 12'd1, EXP_BYTE, 1'b1, 1'b1),
      item_row(8'h5A, 1'b0, 12'd0, EXP_NONE),
      item_row(8'h11, 1'b1, 12'd0, EXP_NONE),
      item_row(8'h22, 1'b1, 12'hFFF, EXP_NONE),
      item_row(8'h33, 1'b1, 12'd4081, EXP_NONE),
      item_row(8'h01, 1'b1, 12'd20, EXP_BYTE),
      item_row(8'h02, 1'b0, 12'd7, EXP_BYTE),
      item_row(8'hFF, 1'b1, 12'd21, EXP_HDR, 1'b0, 1'b0, 8'd2, 8'd1),
      item_row(8'h80, 1'b1, 12'd4080, EXP_HDR, 1'b0, 1'b0, 8'd255, 8'd1),
      cfg_row(REG_MTU, 10'd517),
      item_row(8'h7F, 1'b0, 12'd0, EXP_MODEL),
      cfg_row(REG_NOTIFY, 10'h3FE),
      item_row(8'hC3, 1'b0, 12'd0, EXP_MODEL),
      cfg_row(REG_NOTIFY, 10'h001),
      item_row(8'h3C, 1'b1, 12'd514, EXP_BYTE),
      item_row(8'h96, 1'b1, 12'd515, EXP_HDR, 1'b0, 1'b0, 8'd2, 8'd1),
      cfg_row(REG_MTU, 10'h3FF),
      item_row(8'h69, 1'b1, 12'd515, EXP_HDR, 1'b0, 1'b0, 8'd2, 8'd1),
      cfg_row(REG_MTU, 10'd0),
      item_row(8'h0F, 1'b1, 12'd2, EXP_BYTE),
      item_row(8'hF0, 1'b0, 12'hAAA, EXP_BYTE, 1'b1, 1'b1),
      item_row(8'h55, 1'b1, 12'd21, EXP_HDR, 1'b0, 1'b0, 8'd2, 8'd1),
      item_row(8'hAA, 1'b0, 12'h555, EXP_MODEL)
    };

    idle_pct  = 20;
    stall_pct = 20;
    foreach (opening_rows[i]) begin
      row = opening_rows[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.data, row.first, row.len);
        if (row.chk == EXP_MODEL) begin
          foreach (step_beats[j]) packet_bytes_due.push_back(step_beats[j]);
        end else if (row.chk != EXP_NONE) begin
          if (row.chk == EXP_HDR) begin
            packet_bytes_due.push_back(beat_t'{HDR_MARK, 1'b0, 1'b0});
            packet_bytes_due.push_back(beat_t'{HDR_MARK, 1'b0, 1'b0});
            packet_bytes_due.push_back(beat_t'{row.total, 1'b0, 1'b0});
            packet_bytes_due.push_back(beat_t'{row.idx, 1'b0, 1'b0});
          end
          packet_bytes_due.push_back(beat_t'{row.data, row.pe, row.me});
        end
      end
    end

    // random phases: new config, then a batch of messages
    while (busy_items < RAND_ITEMS) begin
      if (busy_items < RAND_ITEMS - 80) begin
        idle_pct  = 20 * $urandom_range(0, 2);
        stall_pct = 20 * $urandom_range(0, 2);
      end
      r = $urandom_range(0, 99);
      if (r < 55) mtu_pick = $urandom_range(23, 30);
      else if (r < 70) mtu_pick = $urandom_range(31, 517);
      else if (r < 80) mtu_pick = ($urandom_range(0, 1) != 0) ? int'(MTU_MAX) : int'(MTU_MIN);
      else if (r < 90) mtu_pick = $urandom_range(0, 22);
      else mtu_pick = $urandom_range(518, 1023);
      write_reg(REG_MTU, 10'(mtu_pick));
      write_reg(REG_NOTIFY, {9'($urandom), 1'($urandom_range(0, 9) != 0)});
      eff = mtu_pick;
      if (eff < int'(MTU_MIN)) eff = MTU_MIN;
      if (eff > int'(MTU_MAX)) eff = MTU_MAX;
      chunk = eff - int'(FRAG_OVH);

      msgs = $urandom_range(3, 8);
      while (msgs > 0 && busy_items < RAND_ITEMS) begin
        msgs--;
        r = $urandom_range(0, 99);
        opens = 1'b1;
        if (r < 8) begin
          // stray bytes, or the tail of an abandoned message
          opens = 1'b0;
          len   = 0;
          nsend = $urandom_range(1, 3);
        end else if (r < 13) begin
          // zero or oversize length
          len   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_MSG + 1, 4095);
          nsend = $urandom_range(1, 3);
        end else begin
          s = $urandom_range(0, 99);
          if (s < 30) begin
            hi  = (eff - int'(SINGLE_OVH) < 16) ? eff - int'(SINGLE_OVH) : 16;
            len = $urandom_range(1, hi);
          end else if (s < 45) begin
            len = eff - int'(SINGLE_OVH) + $urandom_range(0, 1);
          end else if (s < 90) begin
            len = $urandom_range(eff - 2, eff - 2 + 2 * chunk);
          end else begin
            len = $urandom_range(eff - 2, MAX_MSG);
          end
          nsend = len;
          // cut long or unlucky messages short; a new first byte abandons them
          if (nsend > 96 || $urandom_range(0, 9) == 0)
            nsend = $urandom_range(1, (len < 8) ? len : 8);
        end
        for (int k = 0; k < nsend; k++)
          feed(8'($urandom), opens && k == 0, (opens && k == 0) ? 12'(len) : 12'($urandom));
      end
    end

    // drain and report
    in_valid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    wait_drained();
    if (bad_bytes == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
